// ===== design/btrr_pkg.sv =====
// ----------------------------------------------------------------------------
// btrr_pkg
// Shared types and constants of the bitmap text row renderer.
// ----------------------------------------------------------------------------
package btrr_pkg;

	localparam int GLYPH_COUNT_DEF = 256;
	localparam int MAX_DIM_DEF     = 4096;

	localparam int GLYPH_ROWS   = 16;
	localparam int GLYPH_COLS   = 8;
	localparam int CUR_XW       = 13;
	localparam int CUR_YW       = 14;
	localparam int DIM_W        = 13;
	localparam int CMP_W        = 15;
	localparam int CURSOR_Y_MAX = 16383;
	localparam int PIX_W        = 29;
	localparam int ADDR_W       = 33;
	localparam int QDEPTH       = 4;

	localparam logic [7:0] CODE_END     = 8'd0;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	localparam logic [2:0] CFG_FB_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_FB_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_SCANLINE   = 3'd2;
	localparam logic [2:0] CFG_FRAME_BASE = 3'd3;
	localparam logic [2:0] CFG_RGB_ORDER  = 3'd4;

	typedef struct packed {
		logic        req_type;
		logic [11:0] load_index;
		logic [7:0]  load_byte;
		logic [7:0]  char_code;
		logic        first_char;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} req_t;

	typedef struct packed {
		logic [32:0] row_address;
		logic [7:0]  pixel_mask;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic        last_row;
	} row_t;

	// command from the front to the back: a store load or one glyph to draw
	typedef struct packed {
		logic              kind;
		logic [11:0]       load_index;
		logic [7:0]        load_byte;
		logic [7:0]        glyph;
		logic [CUR_XW-1:0] x;
		logic [CUR_YW-1:0] y;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
	} cmd_t;

endpackage

// ===== design/btrr_front.sv =====
// ----------------------------------------------------------------------------
// btrr_front
// Accepts request beats, tracks the text cursor and string state, and turns
// each request into a store load or draw command, or drops it.
// ----------------------------------------------------------------------------
module btrr_front #(
	parameter int GLYPH_COUNT = btrr_pkg::GLYPH_COUNT_DEF,
	parameter int MAX_DIM     = btrr_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  btrr_pkg::req_t                req,
	input  logic [btrr_pkg::DIM_W-1:0]    fb_width,
	input  logic [btrr_pkg::DIM_W-1:0]    fb_height,
	input  logic                          q_full,
	output logic                          push,
	output btrr_pkg::cmd_t                cmd
);
	import btrr_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;

	logic [CUR_XW-1:0] cx_q, nx;
	logic [CUR_YW-1:0] cy_q, ny;
	logic [11:0]       lsx_q, nl;
	logic [7:0]        red_q, green_q, blue_q, nr, ng, nb;
	logic              done_q, nd;
	logic              accept;
	logic [CMP_W-1:0]  clamp_w, clamp_h, ysum;
	logic [8:0]        code9;
	logic [7:0]        glyph;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	assign clamp_w = ({2'b00, fb_width} > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
	                                                        : {2'b00, fb_width};
	assign clamp_h = ({2'b00, fb_height} > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
	                                                         : {2'b00, fb_height};

	// code modulo glyph count; the count is at least half the code range
	assign code9 = {1'b0, req.char_code};
	assign glyph = (code9 >= 9'(GLYPH_COUNT)) ? 8'(code9 - 9'(GLYPH_COUNT))
	                                          : req.char_code;

	always_comb begin
		nx   = cx_q;
		ny   = cy_q;
		nl   = lsx_q;
		nr   = red_q;
		ng   = green_q;
		nb   = blue_q;
		nd   = done_q;
		push = 1'b0;
		ysum = '0;
		cmd  = '0;
		if (accept) begin
			if (req.req_type == REQ_LOAD) begin
				// drop loads beyond the store
				push           = ({1'b0, req.load_index} < 13'(STORE_DEPTH));
				cmd.kind       = REQ_LOAD;
				cmd.load_index = req.load_index;
				cmd.load_byte  = req.load_byte;
			end else begin
				if (req.first_char) begin
					nx = {1'b0, req.origin_x};
					ny = {2'b00, req.origin_y};
					nl = req.origin_x;
					nr = req.red;
					ng = req.green;
					nb = req.blue;
					nd = 1'b0;
				end
				if (!nd) begin
					if (req.char_code == CODE_END) begin
						nd = 1'b1;
					end else begin
						if (req.char_code == CODE_NEWLINE) begin
							nx   = {1'b0, nl};
							ysum = {1'b0, ny} + CMP_W'(GLYPH_ROWS);
							ny   = (ysum > CMP_W'(CURSOR_Y_MAX)) ? CUR_YW'(CURSOR_Y_MAX)
							                                     : ysum[CUR_YW-1:0];
						end
						if (clamp_w <= {2'b00, nx} + CMP_W'(GLYPH_COLS)) begin
							// clipped on the right: keep the cursor
						end else if (clamp_h <= {1'b0, ny} + CMP_W'(GLYPH_ROWS)) begin
							nd = 1'b1;
						end else begin
							push      = 1'b1;
							cmd.kind  = REQ_DRAW;
							cmd.glyph = glyph;
							cmd.x     = nx;
							cmd.y     = ny;
							cmd.red   = nr;
							cmd.green = ng;
							cmd.blue  = nb;
							nx        = nx + CUR_XW'(GLYPH_COLS);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			lsx_q   <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			done_q  <= 1'b1;
		end else begin
			cx_q    <= nx;
			cy_q    <= ny;
			lsx_q   <= nl;
			red_q   <= nr;
			green_q <= ng;
			blue_q  <= nb;
			done_q  <= nd;
		end
	end

endmodule

// ===== design/btrr_queue.sv =====
// ----------------------------------------------------------------------------
// btrr_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module btrr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  btrr_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output btrr_pkg::cmd_t head
);
	import btrr_pkg::*;

	localparam int QAW = $clog2(QDEPTH);

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   count_q;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/btrr_back.sv =====
// ----------------------------------------------------------------------------
// btrr_back
// Holds the glyph store, applies loads and expands each draw command into
// sixteen row write beats.
// ----------------------------------------------------------------------------
module btrr_back #(
	parameter int GLYPH_COUNT = btrr_pkg::GLYPH_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  btrr_pkg::cmd_t                head,
	output logic                          pop,
	input  logic [btrr_pkg::DIM_W-1:0]    scanline_width,
	input  logic [31:0]                   frame_base,
	input  logic                          rgb_order,
	output logic                          row_valid,
	input  logic                          row_stall,
	output btrr_pkg::row_t                row
);
	import btrr_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int GW          = $clog2(GLYPH_COUNT);
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int PROD_W      = CUR_YW + DIM_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ROWS = 2'd2;

	logic [7:0]        store_q [STORE_DEPTH];
	logic [1:0]        state_q;
	logic [7:0]        glyph_q;
	logic [CUR_XW-1:0] x_q;
	logic [7:0]        red_q, green_q, blue_q;
	logic [PROD_W-1:0] prod_q;
	logic [PIX_W-1:0]  pix_q;
	logic [3:0]        row_q;
	logic              load_we;
	logic              adv;
	logic [AW-1:0]     rd_addr;

	logic              valid_s2;
	logic [7:0]        mask_s2;
	logic [32:0]       addr_s2;
	logic [7:0]        b0_s2, b1_s2, b2_s2;
	logic              last_s2;

	assign pop     = (state_q == ST_IDLE) && head_valid;
	assign load_we = pop && (head.kind == REQ_LOAD);
	assign adv     = (state_q == ST_ROWS) && (!valid_s2 || !row_stall);
	assign rd_addr = {glyph_q[GW-1:0], row_q};

	// glyph store; read data holds while the output beat is stalled
	always_ff @(posedge clk) begin
		if (load_we) begin
			store_q[head.load_index[AW-1:0]] <= head.load_byte;
		end
		if (adv) begin
			mask_s2 <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			glyph_q <= head.glyph;
			x_q     <= head.x;
			red_q   <= head.red;
			green_q <= head.green;
			blue_q  <= head.blue;
			prod_q  <= PROD_W'(head.y) * PROD_W'(scanline_width);
		end
		if (state_q == ST_MUL) begin
			pix_q <= PIX_W'(x_q) + PIX_W'(prod_q);
		end else if (adv) begin
			pix_q <= pix_q + PIX_W'(scanline_width);
		end
		if (adv) begin
			addr_s2 <= {1'b0, frame_base} + ADDR_W'({pix_q, 2'b00});
			b0_s2   <= rgb_order ? red_q : blue_q;
			b1_s2   <= green_q;
			b2_s2   <= rgb_order ? blue_q : red_q;
			last_s2 <= (row_q == 4'(GLYPH_ROWS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!row_stall) begin
				valid_s2 <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && head.kind == REQ_DRAW) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					row_q   <= '0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (adv) begin
						row_q <= row_q + 1'b1;
						if (row_q == 4'(GLYPH_ROWS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign row_valid = valid_s2;

	always_comb begin
		row.row_address = addr_s2;
		row.pixel_mask  = mask_s2;
		row.byte0       = b0_s2;
		row.byte1       = b1_s2;
		row.byte2       = b2_s2;
		row.last_row    = last_s2;
	end

endmodule

// ===== design/bitmap_text_row_renderer.sv =====
// ----------------------------------------------------------------------------
// bitmap_text_row_renderer
// Draws 8x16 glyphs from a loaded glyph store as framebuffer row writes.
// ----------------------------------------------------------------------------
// The front takes one request beat per cycle while its four-entry command
// queue has room; dropped requests (clipped, ended string, end code) never
// reach the queue. The back runs one command at a time: a load is stored
// when popped; a draw pops with the cursor_y times scanline_width multiply,
// adds cursor_x, then gives sixteen row beats at one per cycle unless
// row_stall holds them. The row output is registered; while a beat waits,
// the front accepts until the queue is full. Glyph entries must be loaded
// before they are drawn; an unloaded entry gives an arbitrary pixel mask.
module bitmap_text_row_renderer #(
	parameter int GLYPH_COUNT = btrr_pkg::GLYPH_COUNT_DEF,
	parameter int MAX_DIM     = btrr_pkg::MAX_DIM_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_stall,
	input  btrr_pkg::req_t req,
	output logic           row_valid,
	input  logic           row_stall,
	output btrr_pkg::row_t row
);
	import btrr_pkg::*;

	logic [DIM_W-1:0] fb_width_q, fb_height_q, scanline_q;
	logic [31:0]      frame_base_q;
	logic             rgb_order_q;

	logic q_full, push, pop, head_valid;
	cmd_t push_cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q   <= '0;
			fb_height_q  <= '0;
			scanline_q   <= '0;
			frame_base_q <= '0;
			rgb_order_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FB_WIDTH:   fb_width_q   <= cfg_data[DIM_W-1:0];
				CFG_FB_HEIGHT:  fb_height_q  <= cfg_data[DIM_W-1:0];
				CFG_SCANLINE:   scanline_q   <= cfg_data[DIM_W-1:0];
				CFG_FRAME_BASE: frame_base_q <= cfg_data;
				CFG_RGB_ORDER:  rgb_order_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	btrr_front #(
		.GLYPH_COUNT (GLYPH_COUNT),
		.MAX_DIM     (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.fb_width  (fb_width_q),
		.fb_height (fb_height_q),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	btrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	btrr_back #(
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.scanline_width (scanline_q),
		.frame_base     (frame_base_q),
		.rgb_order      (rgb_order_q),
		.row_valid      (row_valid),
		.row_stall      (row_stall),
		.row            (row)
	);

endmodule
